// ===== sv/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// tcw_pkg: shared constants for the text console cell writer
// Field widths, control byte codes and default geometry.
// ----------------------------------------------------------------------------
package tcw_pkg;

  // default geometry
  localparam int DEF_COLUMNS   = 80;
  localparam int DEF_ROWS      = 25;
  localparam int DEF_TAB_WIDTH = 8;

  // request / result field widths
  localparam int OP_W    = 1;
  localparam int CHAR_W  = 8;
  localparam int ROW_W   = 5;
  localparam int COL_W   = 7;
  localparam int ATTR_W  = 8;
  localparam int CELL_W  = CHAR_W + ATTR_W;

  localparam int S_DATA_W = 24;  // char, row, col packed, padded to bytes
  localparam int M_DATA_W = 32;  // row, col, char, attr, scrolled, padded

  // request kinds carried in tuser
  localparam logic [OP_W-1:0] OP_PUT  = 1'b0;
  localparam logic [OP_W-1:0] OP_READ = 1'b1;

  // control bytes
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;

  localparam logic [ATTR_W-1:0] RESET_ATTR = 8'd7;
  localparam logic [CELL_W-1:0] RESET_CELL = {RESET_ATTR, CH_SPACE};

endpackage

// ===== sv/text_console_char_writer_unit.sv =====
// ----------------------------------------------------------------------------
// text_console_char_writer_unit: text console cell writer
// Cell store with cursor, control byte handling, scroll and cell read-back.
// ----------------------------------------------------------------------------
//
//  channel   dir  tdata fields (low bit up)                    tuser
//  --------  ---  -------------------------------------------  -----
//  s_axis    in   char_code, read_row, read_col                op
//  m_axis    out  cursor_row, cursor_col, cell_char, cell_attr, -
//                 scrolled
//  cfg       in   text_attr (write enable + data, no address)  -
//
//  States per request, accept to result loaded: control byte EXEC, FINISH;
//  printable byte EXEC, WRITE, FINISH; cell read EXEC, READ, FINISH (out of
//  range: EXEC, FINISH); a scroll adds SCROLL, then BLANK over the bottom line.
//  The cell store has one write and one registered read port; a single
//  address unit ((row + row base) mod ROWS) * COLUMNS + col serves every
//  request and the scroll start. Scrolling rotates a row base, so only the
//  new bottom line is rewritten. After rst the store is cleared to
//  space/attr 7 with s_tready low; cfg writes are taken throughout.
//  One request at a time; a stalled result waits in the output register and
//  the next request is taken meanwhile, then held until the output frees.
//
module text_console_char_writer_unit
  import tcw_pkg::*;
#(
  parameter int COLUMNS   = DEF_COLUMNS,
  parameter int ROWS      = DEF_ROWS,
  parameter int TAB_WIDTH = DEF_TAB_WIDTH
) (
  input  logic                clk,
  input  logic                rst,

  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [S_DATA_W-1:0] s_tdata,   // char_code[7:0], read_row[12:8],
                                         // read_col[19:13], zero[23:20]
  input  logic [OP_W-1:0]     s_tuser,   // op

  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata,   // cursor_row[4:0], cursor_col[11:5],
                                         // cell_char[19:12], cell_attr[27:20],
                                         // scrolled[28], zero[31:29]

  input  logic                cfg_we,
  input  logic [ATTR_W-1:0]   cfg_wdata  // text_attr
);

  localparam int DEPTH = ROWS * COLUMNS;
  localparam int AW    = $clog2(DEPTH);
  localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CW    = $clog2(COLUMNS);
  localparam int PW    = (TAB_WIDTH > 1) ? $clog2(TAB_WIDTH) : 1;
  localparam int XW    = $clog2(COLUMNS + TAB_WIDTH);
  localparam int LAST_PHASE = (COLUMNS - 1) % TAB_WIDTH;

  localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);
  localparam logic [CW-1:0] LAST_COL = CW'(COLUMNS - 1);
  localparam logic [AW-1:0] LAST_ADR = AW'(DEPTH - 1);
  localparam logic [PW-1:0] TAB_TOP  = PW'(TAB_WIDTH - 1);

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_EXEC, ST_READ, ST_WRITE, ST_SCROLL, ST_BLANK, ST_FINISH
  } state_t;

  state_t state;

  // latched request
  logic [OP_W-1:0]   req_op;
  logic [CHAR_W-1:0] req_char;
  logic [ROW_W-1:0]  req_row;
  logic [COL_W-1:0]  req_col;

  // cursor, tab phase (cur_col mod TAB_WIDTH), scroll base
  logic [RW-1:0] cur_row;
  logic [CW-1:0] cur_col;
  logic [PW-1:0] tab_phase;
  logic [RW-1:0] row_base;

  logic [ATTR_W-1:0] text_attr;
  logic [AW-1:0]     clr_addr;
  logic [CW-1:0]     blank_col;
  logic [AW-1:0]     addr_q;
  logic              res_scrolled;

  // cell store
  logic [CELL_W-1:0] mem [DEPTH];
  logic [CELL_W-1:0] rdata;
  logic              we;
  logic [AW-1:0]     waddr;
  logic [CELL_W-1:0] wdata;

  // shared address unit
  logic [RW-1:0] au_row;
  logic [CW-1:0] au_col;
  logic [RW:0]   au_sum;
  logic [RW:0]   au_prow;
  logic [AW-1:0] au_addr;

  logic [PW-1:0] phase_inc;
  logic [PW-1:0] phase_dec;
  logic [XW-1:0] tab_x;
  logic          tab_clamp;
  logic          rd_in_range;
  logic [CELL_W-1:0] rd_cell;

  assign s_tready = (state == ST_IDLE);

  assign rd_in_range = (32'(req_row) < ROWS) && (32'(req_col) < COLUMNS);
  assign rd_cell     = rd_in_range ? rdata : '0;

  always_comb begin
    if (state == ST_SCROLL) begin
      // old base is the old top line, which becomes the new bottom line
      au_row = '0;
      au_col = '0;
    end else if (req_op == OP_READ) begin
      au_row = RW'(req_row);
      au_col = CW'(req_col);
    end else begin
      au_row = cur_row;
      au_col = cur_col;
    end
    au_sum  = (RW+1)'(au_row) + (RW+1)'(row_base);
    au_prow = (au_sum >= (RW+1)'(ROWS)) ? au_sum - (RW+1)'(ROWS) : au_sum;
    au_addr = AW'(au_prow[RW-1:0]) * AW'(COLUMNS) + AW'(au_col);
  end

  always_comb begin
    phase_inc = (tab_phase == TAB_TOP) ? '0 : tab_phase + 1'b1;
    phase_dec = (tab_phase == '0) ? TAB_TOP : tab_phase - 1'b1;
    tab_x     = XW'(cur_col) + XW'(TAB_WIDTH) - XW'(tab_phase);
    tab_clamp = (tab_x >= XW'(COLUMNS));
  end

  // write port select
  always_comb begin
    we    = 1'b0;
    waddr = addr_q;
    wdata = {text_attr, CH_SPACE};
    case (state)
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = clr_addr;
        wdata = RESET_CELL;
      end
      ST_WRITE: begin
        we    = 1'b1;
        wdata = {text_attr, req_char};
      end
      ST_BLANK: begin
        we    = 1'b1;
      end
      default: begin
        we    = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[addr_q];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clr_addr     <= '0;
      cur_row      <= '0;
      cur_col      <= '0;
      tab_phase    <= '0;
      row_base     <= '0;
      text_attr    <= RESET_ATTR;
      m_tvalid     <= 1'b0;
      res_scrolled <= 1'b0;
    end else begin
      if (cfg_we) begin
        text_attr <= cfg_wdata;
      end
      // a result taken while no new one loads frees the output
      if (m_tvalid && m_tready && state != ST_FINISH) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == LAST_ADR) begin
            state <= ST_IDLE;
          end
        end

        ST_IDLE: begin
          if (s_tvalid) begin
            req_op       <= s_tuser;
            req_char     <= s_tdata[7:0];
            req_row      <= s_tdata[12:8];
            req_col      <= s_tdata[19:13];
            res_scrolled <= 1'b0;
            state        <= ST_EXEC;
          end
        end

        ST_EXEC: begin
          addr_q <= au_addr;
          if (req_op == OP_READ) begin
            state <= rd_in_range ? ST_READ : ST_FINISH;
          end else begin
            case (req_char)
              CH_NEWLINE: begin
                cur_col   <= '0;
                tab_phase <= '0;
                if (cur_row == LAST_ROW) begin
                  res_scrolled <= 1'b1;
                  state        <= ST_SCROLL;
                end else begin
                  cur_row <= cur_row + 1'b1;
                  state   <= ST_FINISH;
                end
              end
              CH_RETURN: begin
                cur_col   <= '0;
                tab_phase <= '0;
                state     <= ST_FINISH;
              end
              CH_TAB: begin
                state <= ST_FINISH;
                if (tab_clamp) begin
                  cur_col   <= LAST_COL;
                  tab_phase <= PW'(LAST_PHASE);
                end else begin
                  cur_col   <= CW'(tab_x);
                  tab_phase <= '0;
                end
              end
              CH_BACKSPACE: begin
                state <= ST_FINISH;
                if (cur_col == '0 && cur_row != '0) begin
                  cur_col   <= LAST_COL;
                  tab_phase <= PW'(LAST_PHASE);
                  cur_row   <= cur_row - 1'b1;
                end else if (cur_col != '0) begin
                  cur_col   <= cur_col - 1'b1;
                  tab_phase <= phase_dec;
                end
              end
              default: begin
                state <= ST_WRITE;
              end
            endcase
          end
        end

        ST_READ: begin
          // rdata lands at this edge
          state <= ST_FINISH;
        end

        ST_WRITE: begin
          if (cur_col == LAST_COL) begin
            cur_col   <= '0;
            tab_phase <= '0;
            if (cur_row == LAST_ROW) begin
              res_scrolled <= 1'b1;
              state        <= ST_SCROLL;
            end else begin
              cur_row <= cur_row + 1'b1;
              state   <= ST_FINISH;
            end
          end else begin
            cur_col   <= cur_col + 1'b1;
            tab_phase <= phase_inc;
            state     <= ST_FINISH;
          end
        end

        ST_SCROLL: begin
          addr_q    <= au_addr;
          row_base  <= (row_base == LAST_ROW) ? '0 : row_base + 1'b1;
          blank_col <= '0;
          state     <= ST_BLANK;
        end

        ST_BLANK: begin
          addr_q    <= addr_q + 1'b1;
          blank_col <= blank_col + 1'b1;
          if (blank_col == LAST_COL) begin
            state <= ST_FINISH;
          end
        end

        ST_FINISH: begin
          if (!m_tvalid || m_tready) begin
            m_tdata <= {3'b000, res_scrolled,
                        (req_op == OP_READ) ? rd_cell : {CELL_W{1'b0}},
                        COL_W'(cur_col), ROW_W'(cur_row)};
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_accept_to_exec: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == ST_EXEC))
    else $error("accepted request did not start execution");

  a_blank_walk: assert property (@(posedge clk) disable iff (rst)
    (state == ST_BLANK && blank_col != LAST_COL) |=>
      (state == ST_BLANK && addr_q == $past(addr_q) + 1'b1))
    else $error("bottom line blank walk broke off");

  a_scroll_cursor: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH && res_scrolled) |-> (cur_col == '0 && cur_row == LAST_ROW))
    else $error("scroll left cursor off the bottom line start");

  a_geometry: assert property (@(posedge clk) disable iff (rst)
    (32'(cur_row) < ROWS) && (32'(cur_col) < COLUMNS) && (32'(row_base) < ROWS))
    else $error("cursor or row base out of range");

  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |=> !(s_tvalid && $past(s_tready)))
    else $error("request taken during store clear");
`endif

endmodule
